FILE: hw/rtl/lie_pkg.sv
// Package with the constants, item types and control structs of the LCP interval enumerator.
package lie_pkg;

    localparam int LCP_W       = 20;
    localparam int STACK_DEPTH = 64;
    localparam int MAX_LENGTH  = 1048576;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int POS_W       = $clog2(MAX_LENGTH);

    typedef struct packed {
        logic [LCP_W-1:0] lcp_elem;
        logic             end_of_array;
    } t_in_item;

    typedef struct packed {
        logic [LCP_W-1:0] interval_lcp;
        logic [LCP_W-1:0] left_bound;
        logic [LCP_W-1:0] right_bound;
        logic             run_last;
        logic             stack_overflow;
    } t_out_item;

    typedef struct packed {
        logic [LCP_W-1:0] lcp;
        logic [LCP_W-1:0] left;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic probe_step;
        logic probe_end;
        logic pop;
        logic close_end;
        logic flush_start;
        logic fin_move;
    } t_cmd;

    typedef struct packed {
        logic idx_zero;
        logic in_last;
        logic last;
        logic full;
        logic ovf;
        logic above;
        logic at_root;
        logic hold_v;
        logic hold_free;
        logic out_free;
    } t_stat;

endpackage

FILE: hw/rtl/lie_ctrl.sv
// Controller state machine that sequences probe, pop, push and flush steps for each item.
module lie_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lie_pkg::t_stat i_stat,
    output logic           o_stall,
    output lie_pkg::t_cmd  o_cmd
);
    import lie_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CLOSE,
        S_FLUSH,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   n_stall;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !r_stall) begin
                    cmd.accept = 1'b1;
                    if (i_stat.idx_zero) begin
                        n_state = S_IDLE;
                    end else if (i_stat.in_last && i_stat.full && !i_stat.ovf) begin
                        n_state = S_PROBE;
                    end else begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_PROBE: begin
                if (i_stat.above && !i_stat.at_root) begin
                    cmd.probe_step = 1'b1;
                end else begin
                    cmd.probe_end = 1'b1;
                    n_state       = S_CLOSE;
                end
            end
            S_CLOSE, S_FLUSH: begin
                if (i_stat.above && !i_stat.at_root) begin
                    cmd.pop = i_stat.hold_free;
                end else begin
                    cmd.close_end = 1'b1;
                    if (r_state == S_CLOSE && i_stat.last) begin
                        cmd.flush_start = 1'b1;
                        n_state         = S_FLUSH;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!i_stat.hold_v) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    cmd.fin_move = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_stall = r_stall;
    assign o_cmd   = cmd;

endmodule

FILE: hw/rtl/lie_datapath.sv
// Datapath with the interval stack memory, top and position registers, and the result registers.
module lie_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lie_pkg::t_in_item i_data,
    input  lie_pkg::t_cmd     i_cmd,
    input  logic              i_stall,
    output lie_pkg::t_stat    o_stat,
    output logic              o_valid,
    output lie_pkg::t_out_item o_data
);
    import lie_pkg::*;

    t_entry           mem [STACK_DEPTH];
    t_entry           r_rd;
    t_entry           r_top;
    logic             r_use_rd;
    logic [LVL_W-1:0] r_level;
    logic [IDX_W-1:0] r_cur;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_idx;
    logic [LCP_W-1:0] r_value;
    logic [LCP_W-1:0] r_left;
    logic [LCP_W-1:0] r_right;
    logic             r_last;
    logic             r_allow;
    logic             r_ovf;
    t_out_item        r_hold;
    logic             r_hold_v;
    t_out_item        r_out;
    logic             r_out_v;
    logic             n_out_v;

    t_entry ent;
    logic   full;
    logic   above;
    logic   below;
    logic   out_free;
    logic   push;
    logic   load_out;

    always_comb begin
        if (!r_use_rd) begin
            ent = r_top;
        end else if (r_cur == '0) begin
            ent = '0;
        end else begin
            ent = r_rd;
        end
        full     = (r_level == LVL_W'(STACK_DEPTH));
        above    = (ent.lcp > r_value);
        below    = (r_value > ent.lcp);
        out_free = !r_out_v || !i_stall;
        push     = i_cmd.close_end && below && r_allow && !full;
        load_out = (i_cmd.pop && r_hold_v) || i_cmd.fin_move;
        n_out_v  = load_out || (r_out_v && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[r_level[IDX_W-1:0]] <= '{lcp: r_value, left: r_left};
        end
        if (i_cmd.pop || i_cmd.probe_step) begin
            r_rd <= mem[r_cur - IDX_W'(1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value <= i_data.lcp_elem;
            r_last  <= i_data.end_of_array;
            r_idx   <= r_pos;
            r_right <= LCP_W'(r_pos - POS_W'(1));
            r_allow <= !(i_data.end_of_array && full);
        end else if (i_cmd.flush_start) begin
            r_value <= '0;
            r_right <= LCP_W'(r_idx);
        end
        if (i_cmd.accept) begin
            r_left <= LCP_W'(r_pos - POS_W'(1));
        end else if (i_cmd.flush_start) begin
            r_left <= LCP_W'(r_idx);
        end else if (i_cmd.pop) begin
            r_left <= ent.left;
        end
        if (i_cmd.pop) begin
            r_hold <= '{interval_lcp: ent.lcp, left_bound: ent.left,
                        right_bound: r_right, run_last: 1'b0, stack_overflow: 1'b0};
        end
        if (load_out) begin
            r_out <= '{interval_lcp: r_hold.interval_lcp, left_bound: r_hold.left_bound,
                       right_bound: r_hold.right_bound, run_last: i_cmd.fin_move,
                       stack_overflow: r_ovf};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_use_rd <= 1'b0;
            r_level  <= LVL_W'(1);
            r_cur    <= '0;
            r_pos    <= '0;
            r_ovf    <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_out_v <= n_out_v;
            if (i_cmd.accept) begin
                if (i_data.end_of_array) begin
                    r_pos <= '0;
                end else if (r_pos != POS_W'(MAX_LENGTH - 1)) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (i_cmd.probe_step) begin
                r_cur    <= r_cur - IDX_W'(1);
                r_use_rd <= 1'b1;
            end
            if (i_cmd.probe_end) begin
                if (below) begin
                    r_ovf <= 1'b1;
                end
                r_cur    <= IDX_W'(r_level - LVL_W'(1));
                r_use_rd <= 1'b0;
            end
            if (i_cmd.pop) begin
                r_cur    <= r_cur - IDX_W'(1);
                r_level  <= r_level - LVL_W'(1);
                r_use_rd <= 1'b1;
                r_hold_v <= 1'b1;
            end
            if (i_cmd.close_end) begin
                r_use_rd <= 1'b0;
                if (push) begin
                    r_top   <= '{lcp: r_value, left: r_left};
                    r_level <= r_level + LVL_W'(1);
                    r_cur   <= r_level[IDX_W-1:0];
                end else begin
                    r_top <= ent;
                    if (below) begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            if (i_cmd.fin_move) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.idx_zero  = (r_pos == '0);
        o_stat.in_last   = i_data.end_of_array;
        o_stat.last      = r_last;
        o_stat.full      = full;
        o_stat.ovf       = r_ovf;
        o_stat.above     = above;
        o_stat.at_root   = (r_cur == '0);
        o_stat.hold_v    = r_hold_v;
        o_stat.hold_free = !r_hold_v || out_free;
        o_stat.out_free  = out_free;
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

FILE: hw/rtl/lcp_interval_enumerator_top.sv
// Top level of the LCP interval enumerator: controller and datapath.
//
//  Channel  Direction  Handshake            Payload
//  input    in         i_valid / o_stall    i_data (lcp_elem, end_of_array)
//  output   out        o_valid / i_stall    o_data (interval_lcp, left_bound, right_bound,
//                                                   run_last, stack_overflow)
//
// An item at array index zero is only accepted. Any other item passes through the close
// step, which pops each closed interval, then a finish step, with a flush pass on the last element.
// When the last element arrives on a full stack before any overflow, a read-only walk down
// the stack comes before the close step.
// The stack memory is read at most once per cycle, one entry per probe step or pop.
// A synchronous reset leaves only the root open; no clearing pass is needed.
// A stall on the output holds pops once the result registers are both occupied.
module lcp_interval_enumerator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  lie_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output lie_pkg::t_out_item  o_data
);
    import lie_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lie_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    lie_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .i_stall (i_stall),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

FILE: hw/rtl/lie_checker.sv
// Port-level checker for the LCP interval enumerator, bound to the top level.
module lie_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input lie_pkg::t_in_item  i_data,
    input logic               o_valid,
    input logic               i_stall,
    input lie_pkg::t_out_item o_data
);
    import lie_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("Stalled output transaction changed.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.run_last |-> o_stall)
        else $error("Input taken while an item still has results to deliver.");

    a_no_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.interval_lcp != '0)
        else $error("Root interval was emitted.");

endmodule

bind lcp_interval_enumerator_top lie_checker u_lie_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
